@@ hdl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEF_CAPACITY  = 16;
  localparam int DEF_KEY_WIDTH = 32;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // latch the request key
    logic ins_start;   // set up the walk from the tail, read the last entry
    logic ins_shift;   // move the entry just read up one slot, read the next
    logic ins_place;   // write the key into the free slot, report
    logic rem_start;   // read the entry at the head
    logic rem_finish;  // report the head entry, advance the head
    logic emit_full;   // report an insert dropped on a full queue
    logic emit_empty;  // report a remove on an empty queue
  } spq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic walk_stop;   // free slot found: no entry left or entry below key
  } spq_stat_t;

endpackage

@@ hdl/sorted_priority_queue_top.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded priority queue of signed keys kept in ascending order; insert
// and remove-smallest requests, one result per request.
//
//   channel  | handshake          | fields
//   ---------+--------------------+----------------------------------------
//   request  | start && !busy     | operation, key_in
//   result   | done (one cycle)   | removed_key, status, entry_count,
//            |                    | is_empty
//
// Removes read the head entry, then report it; dropped inserts and removes
// on empty are reported without touching the store. An insert walks from
// the tail, moving each entry not below the key up one slot, then writes
// the key into the free slot. busy is high only for removes and walks.
// Reset clears count, pointers and done; the key store needs no clearing.
// The result strobe cannot be held off.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top
  import spq_pkg::*;
#(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int KEY_WIDTH = DEF_KEY_WIDTH
)(
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            operation,
  input  logic signed [KEY_WIDTH-1:0]     key_in,
  output logic                            done,
  output logic signed [KEY_WIDTH-1:0]     removed_key,
  output logic [1:0]                      status,
  output logic [$clog2(CAPACITY+1)-1:0]   entry_count,
  output logic                            is_empty
);

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  spq_datapath #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .key_in      (key_in),
    .stat        (stat),
    .done        (done),
    .removed_key (removed_key),
    .status      (status),
    .entry_count (entry_count),
    .is_empty    (is_empty)
  );

endmodule

@@ hdl/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer for insert walks and removes of the sorted priority queue.
// ----------------------------------------------------------------------------
module spq_ctrl
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      operation,
  input  spq_stat_t stat,
  output spq_cmd_t  cmd,
  output logic      busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_REM
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (operation == OP_INSERT) begin
            if (stat.full) begin
              cmd.emit_full = 1'b1;
            end else begin
              cmd.ins_start = 1'b1;
              state_next    = S_WALK;
            end
          end else begin
            if (stat.empty) begin
              cmd.emit_empty = 1'b1;
            end else begin
              cmd.rem_start = 1'b1;
              state_next    = S_REM;
            end
          end
        end
      end
      S_WALK: begin
        if (stat.walk_stop) begin
          cmd.ins_place = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.ins_shift = 1'b1;
        end
      end
      S_REM: begin
        cmd.rem_finish = 1'b1;
        state_next     = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.ins_start, cmd.ins_shift, cmd.ins_place, cmd.rem_start,
              cmd.rem_finish, cmd.emit_full, cmd.emit_empty}))
    else $error("spq_ctrl: more than one datapath command");
  a_rem_done: assert property (@(posedge clk) disable iff (rst)
    cmd.rem_start |=> cmd.rem_finish)
    else $error("spq_ctrl: remove not completed in the following cycle");
  a_walk_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_start |-> !stat.full)
    else $error("spq_ctrl: insert walk started on a full queue");
`endif

endmodule

@@ hdl/spq_datapath.sv @@
// ----------------------------------------------------------------------------
// spq_datapath
// Circular key store with head and tail pointers, walk registers and
// result registers.
// ----------------------------------------------------------------------------
module spq_datapath
  import spq_pkg::*;
#(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int KEY_WIDTH = DEF_KEY_WIDTH
)(
  input  logic                            clk,
  input  logic                            rst,
  input  spq_cmd_t                        cmd,
  input  logic signed [KEY_WIDTH-1:0]     key_in,
  output spq_stat_t                       stat,
  output logic                            done,
  output logic signed [KEY_WIDTH-1:0]     removed_key,
  output logic [1:0]                      status,
  output logic [$clog2(CAPACITY+1)-1:0]   entry_count,
  output logic                            is_empty
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY+1);

  function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
    addr_inc = (a == AW'(CAPACITY-1)) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
    addr_dec = (a == '0) ? AW'(CAPACITY-1) : a - AW'(1);
  endfunction

  logic signed [KEY_WIDTH-1:0] mem [CAPACITY];
  logic signed [KEY_WIDTH-1:0] rd_data;
  logic signed [KEY_WIDTH-1:0] key_reg;
  logic [AW-1:0]               head;
  logic [AW-1:0]               tail;
  logic [AW-1:0]               ptr;
  logic [AW-1:0]               wptr;
  logic [CW-1:0]               count;
  logic [CW-1:0]               rem;

  logic [AW-1:0]               rd_addr;
  logic                        wr_en;
  logic signed [KEY_WIDTH-1:0] wr_data;

  assign stat.full      = (count == CW'(CAPACITY));
  assign stat.empty     = (count == '0);
  assign stat.walk_stop = (rem == '0) || (rd_data < key_reg);

  always_comb begin
    priority if (cmd.ins_start) begin
      rd_addr = addr_dec(tail);
    end else if (cmd.ins_shift) begin
      rd_addr = addr_dec(ptr);
    end else begin
      rd_addr = head;
    end
  end

  assign wr_en   = cmd.ins_shift | cmd.ins_place;
  assign wr_data = cmd.ins_place ? key_reg : rd_data;

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // walk and key registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_reg <= key_in;
    end
    if (cmd.ins_start) begin
      ptr  <= addr_dec(tail);
      wptr <= tail;
      rem  <= count;
    end else if (cmd.ins_shift) begin
      ptr  <= addr_dec(ptr);
      wptr <= ptr;
      rem  <= rem - CW'(1);
    end
  end

  // queue pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (cmd.ins_place) begin
        tail  <= addr_inc(tail);
        count <= count + CW'(1);
      end else if (cmd.rem_finish) begin
        head  <= addr_inc(head);
        count <= count - CW'(1);
      end
    end
  end

  // result registers, one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.ins_place | cmd.rem_finish | cmd.emit_full | cmd.emit_empty;
    end
    if (cmd.ins_place) begin
      removed_key <= '0;
      status      <= STATUS_OK;
      entry_count <= count + CW'(1);
      is_empty    <= 1'b0;
    end else if (cmd.rem_finish) begin
      removed_key <= rd_data;
      status      <= STATUS_OK;
      entry_count <= count - CW'(1);
      is_empty    <= (count == CW'(1));
    end else if (cmd.emit_full) begin
      removed_key <= '0;
      status      <= STATUS_FULL;
      entry_count <= count;
      is_empty    <= (count == '0);
    end else if (cmd.emit_empty) begin
      removed_key <= '0;
      status      <= STATUS_EMPTY;
      entry_count <= count;
      is_empty    <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  logic [CW:0] tail_sum;
  assign tail_sum = {1'b0, count} + (CW+1)'(head);

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("spq_datapath: count beyond capacity");
  a_tail_pos: assert property (@(posedge clk) disable iff (rst)
    (tail_sum == (CW+1)'(tail)) || (tail_sum == (CW+1)'(tail) + (CW+1)'(CAPACITY)))
    else $error("spq_datapath: tail not head plus count");
  a_shift_rem: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_shift |-> (rem != '0))
    else $error("spq_datapath: shift with no entry left");
`endif

endmodule
